// ===== sv/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and codes for the maximum-frequency stack.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int unsigned InWidth = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_PUSH_OK   = 2'd0,
    ST_POP_OK    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_SHIFT,
    ENG_FINISH
  } eng_state_e;

  // One queued command
  typedef struct packed {
    op_e                 op;
    logic [InWidth-1:0]  value;
  } cmd_t;

endpackage

// ===== sv/mfs_front.sv =====
// ----------------------------------------------------------------------------
// mfs_front
// Command intake: decodes transactions into a two-entry queue.
// ----------------------------------------------------------------------------
module mfs_front
  import mfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               opcode_i,
  input  logic [InWidth-1:0] value_in_i,
  output logic               busy_o,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_take_i
);

  cmd_t       slot_q [2];
  logic       rd_ptr_q, rd_ptr_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       new_cmd;

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_take_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    new_cmd.op    = opcode_i ? OP_POP : OP_PUSH;
    new_cmd.value = value_in_i;
    rd_ptr_d      = pop  ? ~rd_ptr_q : rd_ptr_q;
    wr_ptr_d      = push ? ~wr_ptr_q : wr_ptr_q;
    cnt_d         = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

// ===== sv/mfs_engine.sv =====
// ----------------------------------------------------------------------------
// mfs_engine
// Executes push/pop over the entry store by sequential scans.
// ----------------------------------------------------------------------------
module mfs_engine
  import mfs_pkg::*;
#(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_take_o,
  output logic               done_o,
  output logic [InWidth-1:0] popped_value_o,
  output logic [1:0]         status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW = $clog2(DEPTH + 1);
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned W  = IW + VW;
  localparam logic [IW-1:0] DepthVal = IW'(DEPTH);

  eng_state_e state_q, state_d;

  logic [W-1:0]  mem [DEPTH];
  logic [W-1:0]  rd_data_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;

  logic [IW-1:0] idx_q, rd_idx_q, total_q, top_q, cnt_q, sel_q;
  logic          rd_vld_q;
  logic [1:0]    hits_q;
  logic [VW-1:0] val_q, cv_q;
  op_e           op_q;
  logic          done_q;
  status_e       status_q;
  logic [InWidth-1:0] popped_q;

  logic [IW-1:0] rd_level;
  logic [VW-1:0] rd_value;
  logic          scan_end, reject;
  logic [IW-1:0] new_level;

  assign rd_level  = rd_data_q[W-1:VW];
  assign rd_value  = rd_data_q[VW-1:0];
  assign scan_end  = (idx_q == total_q) && !rd_vld_q;
  assign new_level = cnt_q + IW'(1);
  assign reject    = (cmd_i.op == OP_PUSH) ? (total_q == DepthVal) : (total_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ENG_IDLE:   if (cmd_valid_i && !reject) state_d = ENG_SCAN;
      ENG_SCAN:   if (scan_end) state_d = (op_q == OP_PUSH) ? ENG_FINISH : ENG_SHIFT;
      ENG_SHIFT:  if (scan_end) state_d = ENG_FINISH;
      ENG_FINISH: state_d = ENG_IDLE;
      default:    state_d = ENG_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    cmd_take_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx_q[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = total_q[AW-1:0];
    wr_data    = {new_level, cv_q};
    case (state_q)
      ENG_IDLE:   cmd_take_o = cmd_valid_i;
      ENG_SCAN:   rd_en = (idx_q != total_q);
      ENG_SHIFT: begin
        rd_en   = (idx_q != total_q);
        wr_en   = rd_vld_q;
        wr_addr = AW'(rd_idx_q - IW'(1));
        wr_data = rd_data_q;
      end
      ENG_FINISH: wr_en = (op_q == OP_PUSH);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ENG_IDLE;
      rd_vld_q <= 1'b0;
      total_q  <= '0;
      top_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      done_q   <= 1'b0;
      case (state_q)
        ENG_IDLE: begin
          if (cmd_valid_i) begin
            op_q   <= cmd_i.op;
            cv_q   <= VW'(cmd_i.value);
            idx_q  <= '0;
            cnt_q  <= '0;
            hits_q <= '0;
            sel_q  <= total_q - IW'(1);
            if (reject) begin
              done_q   <= 1'b1;
              popped_q <= '0;
              status_q <= (cmd_i.op == OP_PUSH) ? ST_PUSH_FULL : ST_POP_EMPTY;
            end
          end
        end
        ENG_SCAN: begin
          if (rd_en) idx_q <= idx_q + IW'(1);
          if (rd_vld_q) begin
            if (op_q == OP_PUSH) begin
              if (rd_value == cv_q) cnt_q <= cnt_q + IW'(1);
            end else if (rd_level == top_q) begin
              sel_q  <= rd_idx_q;
              val_q  <= rd_value;
              hits_q <= (hits_q == 2'd2) ? 2'd2 : hits_q + 2'd1;
            end
          end
          if (scan_end) idx_q <= sel_q + IW'(1);
        end
        ENG_SHIFT: if (rd_en) idx_q <= idx_q + IW'(1);
        ENG_FINISH: begin
          done_q <= 1'b1;
          if (op_q == OP_PUSH) begin
            total_q  <= total_q + IW'(1);
            if (new_level > top_q) top_q <= new_level;
            popped_q <= '0;
            status_q <= ST_PUSH_OK;
          end else begin
            total_q  <= total_q - IW'(1);
            if (hits_q != 2'd2 && top_q != '0) top_q <= top_q - IW'(1);
            popped_q <= InWidth'(val_q);
            status_q <= ST_POP_OK;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_idx_q <= idx_q;
  end

  assign done_o         = done_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;

endmodule

// ===== sv/max_frequency_stack.sv =====
// ----------------------------------------------------------------------------
// max_frequency_stack
// Stack whose pop returns the most frequent value, newest first on ties.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a transaction is taken at a clock edge with start_i
//    high and busy_o low. opcode_i 0 pushes value_in_i, 1 pops.
//  - Result channel: done_o is high for one cycle with popped_value_o and
//    status_o (0 push done, 1 pop done, 2 pop on empty, 3 push when full).
//    Results come in command order; the receiver cannot stall them.
//  - A two-entry command queue sits in front of the execution engine, so
//    busy_o rises only when two commands wait.
//  - A rejected command (full push, empty pop) raises done_o without a
//    scan. A push scans all stored entries through the single read port
//    of the entry memory. A pop scans all entries to find the newest
//    top-level one, then moves the entries above it down one place.
//  - The entry memory port, one read per cycle, sets the throughput.
//  - Reset empties the stack at once; no clearing pass is needed since a
//    value's count is recounted from the stored entries.
// ----------------------------------------------------------------------------
module max_frequency_stack
  import mfs_pkg::*;
#(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [31:0] value_in_i,
  output logic        done_o,
  output logic [31:0] popped_value_o,
  output logic [1:0]  status_o
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // front: intake queue
  mfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .opcode_i    (opcode_i),
    .value_in_i  (value_in_i),
    .busy_o      (busy_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // back: scan / shift engine over the entry store
  mfs_engine #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_take_o     (cmd_take),
    .done_o         (done_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o)
  );

endmodule

// ===== sv/mfs_checker.sv =====
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks for the maximum-frequency stack.
// ----------------------------------------------------------------------------
module mfs_checker
  import mfs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [31:0] popped_value_o,
  input logic [1:0]  status_o
);

  // only a successful pop carries a value
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_POP_OK) |-> popped_value_o == '0)
    else $error("nonzero value on non-pop result");

  // a completed push cannot be followed at once by an empty pop
  a_push_then_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_PUSH_OK) |=> !(done_o && status_o == ST_POP_EMPTY))
    else $error("empty pop right after push");

  // no result right out of reset
  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(rst_ni))
    else $error("result without prior command");

  // a command accepted right out of reset is not answered in that edge
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && $past(!rst_ni)) |-> !done_o)
    else $error("result before accept");

endmodule

bind max_frequency_stack mfs_checker u_mfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .popped_value_o (popped_value_o),
  .status_o       (status_o)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the maximum-frequency stack: a directed burst,
// then random pushes and pops checked against an in-bench frequency model.
// ----------------------------------------------------------------------------
module tb;
  import mfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 1024;

  // Result pair held for each accepted transaction
  typedef struct {
    logic [31:0] value;
    status_e     status;
  } stack_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        opcode_i;
  logic [31:0] value_in_i;
  logic        done_o;
  logic [31:0] popped_value_o;
  logic [1:0]  status_o;

  max_frequency_stack #(.DEPTH(DEPTH), .VALUE_WIDTH(32)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .value_in_i     (value_in_i),
    .done_o         (done_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o)
  );

  // Mirror of the stack: entries in push order, each tagged with its level
  logic [31:0]   stk_val[$];
  int unsigned   stk_lvl[$];
  int unsigned   top_lvl;

  cmd_t          cmd_q[$];
  stack_result_t result_q[$];
  int unsigned   idle_pct;
  int unsigned   errors;

  // Count of value v among stored entries
  function automatic int unsigned count_of(logic [31:0] v);
    int unsigned n;
    n = 0;
    foreach (stk_val[i]) if (stk_val[i] == v) n++;
    return n;
  endfunction

  // Apply one command to the mirror, returning its expected result
  function automatic stack_result_t freq_step(cmd_t c);
    stack_result_t r;
    int sel;
    int unsigned lv;
    bit remains;
    r.value = '0;
    if (c.op == OP_PUSH) begin
      if (stk_val.size() >= DEPTH) begin
        r.status = ST_PUSH_FULL;
      end else begin
        lv = count_of(c.value) + 1;
        stk_val = {stk_val, c.value};
        stk_lvl = {stk_lvl, lv};
        if (lv > top_lvl) top_lvl = lv;
        r.status = ST_PUSH_OK;
      end
    end else if (stk_val.size() == 0) begin
      r.status = ST_POP_EMPTY;
    end else begin
      sel = stk_val.size() - 1;
      for (int i = stk_val.size() - 1; i >= 0; i--) begin
        if (stk_lvl[i] == top_lvl) begin
          sel = i;
          break;
        end
      end
      r.value = stk_val[sel];
      stk_val.delete(sel);
      stk_lvl.delete(sel);
      remains = 0;
      foreach (stk_lvl[i]) if (stk_lvl[i] == top_lvl) remains = 1;
      if (!remains && top_lvl > 0) top_lvl--;
      r.status = ST_POP_OK;
    end
    return r;
  endfunction

  function automatic void add_cmd(op_e op, logic [31:0] v);
    cmd_t c;
    c.op = op;
    c.value = v;
    cmd_q = {cmd_q, c};
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Driver: a transaction is taken when start_i is high and busy_o low.
  // The expectation is computed at the accepting edge, so order is kept.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i    <= 1'b0;
      opcode_i   <= 1'b0;
      value_in_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        result_q = {result_q, freq_step(cmd_q.pop_front())};
      end
      if (start_i && busy_o) begin
        // hold the pending command
      end else if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start_i    <= 1'b1;
        opcode_i   <= cmd_q[0].op;
        value_in_i <= cmd_q[0].value;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: done_o marks a one-cycle result, checked against the oldest
  always @(posedge clk_i) begin
    stack_result_t e;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d",
                 $realtime, popped_value_o, status_o);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $realtime, e.status, status_o);
          errors++;
        end
        if (popped_value_o !== e.value) begin
          $display("%0t: popped_value expected %h actual %h",
                   $realtime, e.value, popped_value_o);
          errors++;
        end
      end
    end
  end

  // Stimulus, fed phase by phase so the idle rate changes along the way
  initial begin
    int unsigned pct[4];
    logic [31:0] pool[8];
    rst_ni = 1'b0;
    errors = 0;
    top_lvl = 0;
    idle_pct = 0;
    pct = '{0, 48, 0, 34};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, field extremes, ties, frequency ordering
    add_cmd(OP_POP, 32'h0);
    add_cmd(OP_PUSH, 32'h0);
    add_cmd(OP_PUSH, 32'hFFFF_FFFF);
    add_cmd(OP_PUSH, 32'hFFFF_FFFF);
    add_cmd(OP_PUSH, 32'h0);
    add_cmd(OP_PUSH, 32'h5555_AAAA);
    add_cmd(OP_PUSH, 32'hFFFF_FFFF);
    add_cmd(OP_POP, 32'hFFFF_FFFF);
    add_cmd(OP_POP, 32'h0);
    add_cmd(OP_POP, 32'h0);
    add_cmd(OP_POP, 32'h0);
    add_cmd(OP_POP, 32'h0);
    add_cmd(OP_POP, 32'h0);
    add_cmd(OP_POP, 32'h0);
    add_cmd(OP_PUSH, 32'hAAAA_5555);
    add_cmd(OP_POP, 32'h1234_5678);
    while (cmd_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);

    // Random phases: half pushes, most from a small pool of values to build
    // real frequency ties and the rest fully random, and half pops
    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p];
      foreach (pool[i]) pool[i] = $urandom();
      for (int n = 0; n < 68; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: add_cmd(OP_PUSH, pool[$urandom_range(7)]);
          4:          add_cmd(OP_PUSH, $urandom());
          default:    add_cmd(OP_POP, $urandom());
        endcase
      end
      while (cmd_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    end

    repeat (4 * DEPTH + 20) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog: about 290 items, each scanning up to DEPTH entries, come to
  // near 12 ms; this leaves a wide margin
  initial begin
    #(50_000_000);
    $display("tb NOT OK");
    $finish;
  end

endmodule
